>>> hdl/wgm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants for the wildcard glob matcher.
// No dependencies; every other file of the block but wgm_ram uses it.
package wgm_pkg;

	localparam int CHAR_W = 21;

	localparam logic [CHAR_W-1:0] STAR_CODE  = CHAR_W'(42);
	localparam logic [CHAR_W-1:0] QMARK_CODE = CHAR_W'(63);

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_CHAR   = 2'd2,
		OP_END    = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic append;
		logic clear;
		logic start;
		logic step;
		logic finish;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic len_zero;
		logic walk_last;
	} sts_t;

endpackage
`default_nettype wire

>>> hdl/wgm_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for the glob matcher: item in, result out.
// Depends on wgm_pkg for the character width.
interface wgm_item_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 operation;
	logic [wgm_pkg::CHAR_W-1:0] character;

	modport source (output valid, output operation, output character, input ready);
	modport sink (input valid, input operation, input character, output ready);
endinterface

interface wgm_result_if;
	logic valid;
	logic ready;
	logic matched;
	logic mask_overflow;

	modport source (output valid, output matched, output mask_overflow, input ready);
	modport sink (input valid, input matched, input mask_overflow, output ready);
endinterface
`default_nettype wire

>>> hdl/wildcard_glob_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the wildcard glob matcher: controller plus datapath.
// Depends on wgm_pkg, wgm_if, wgm_ram, wgm_ctrl and wgm_dp.
//
// channel  direction  payload                        transfer when
// item     in         operation[1:0], character[20:0] item.valid && item.ready
// result   out        matched, mask_overflow         result.valid && result.ready
//
// Append, clear and end-of-string items need no walk. A string character with
// a non-empty mask starts a walk over the mask: the
// mask RAM has one read port and the walk visits one mask position a cycle.
// Reset clears length, flags and match vector at once; mask RAM is not cleared.
// A result held in the output register stalls only the next item, and only
// while result.ready stays low.
module wildcard_glob_matcher #(
	parameter int MAX_MASK = 64
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	wgm_item_if.sink     item,
	wgm_result_if.source result
);

	wgm_pkg::cmd_t cmd;
	wgm_pkg::sts_t sts;

	wgm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.operation),
		.in_ready (item.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wgm_dp #(
		.MAX_MASK(MAX_MASK)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.character    (item.character),
		.sts          (sts),
		.matched      (result.matched),
		.mask_overflow(result.mask_overflow)
	);

endmodule
`default_nettype wire

>>> hdl/wgm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wgm_ram #(
	parameter int WIDTH = 21,
	parameter int DEPTH = 64
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                          wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> hdl/wgm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// Controller of the glob matcher: handshakes, the walk state machine and the
// result valid flag. Depends on wgm_pkg.
module wgm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [1:0]    in_op,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	input  wire wgm_pkg::sts_t sts,
	output wgm_pkg::cmd_t      cmd
);

	wgm_pkg::state_t state_q;
	wgm_pkg::state_t state_next;
	wgm_pkg::op_t    op;
	logic            accept;
	logic            out_valid_q;

	assign op = wgm_pkg::op_t'(in_op);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wgm_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		in_ready   = 1'b0;
		cmd        = '0;
		case (state_q)
			wgm_pkg::ST_IDLE: begin
				// a waiting result may leave in the same cycle
				in_ready = !out_valid_q || out_ready;
			end
			wgm_pkg::ST_WALK: begin
				cmd.step = 1'b1;
				if (sts.walk_last) begin
					state_next = wgm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = wgm_pkg::ST_IDLE;
			end
		endcase
		accept = in_valid && in_ready;
		if (accept) begin
			case (op)
				wgm_pkg::OP_APPEND: cmd.append = 1'b1;
				wgm_pkg::OP_CLEAR:  cmd.clear  = 1'b1;
				wgm_pkg::OP_CHAR: begin
					cmd.start = 1'b1;
					if (!sts.len_zero) begin
						state_next = wgm_pkg::ST_WALK;
					end
				end
				wgm_pkg::OP_END:    cmd.finish = 1'b1;
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_walk_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wgm_pkg::ST_WALK |-> !in_ready)
		else $error("item taken during a mask walk");

	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("end of string without a result");

	a_walk_continues: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == wgm_pkg::ST_WALK && !sts.walk_last |=> state_q == wgm_pkg::ST_WALK)
		else $error("walk left before the last mask position");

	a_empty_mask_no_walk: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start && sts.len_zero |=> state_q == wgm_pkg::ST_IDLE)
		else $error("walk started on an empty mask");

endmodule
`default_nettype wire

>>> hdl/wgm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// Datapath of the glob matcher: mask RAM, length, match vector and the
// per-position recurrence. Depends on wgm_pkg and wgm_ram.
module wgm_dp #(
	parameter int MAX_MASK = 64
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire wgm_pkg::cmd_t              cmd,
	input  wire logic [wgm_pkg::CHAR_W-1:0] character,
	output wgm_pkg::sts_t                   sts,
	output logic                            matched,
	output logic                            mask_overflow
);

	localparam int AW = (MAX_MASK > 1) ? $clog2(MAX_MASK) : 1;
	localparam int LW = $clog2(MAX_MASK + 1);

	logic [LW-1:0]              mask_length_q;
	logic [MAX_MASK-1:0]        bits_q;
	logic                       at_start_q;
	logic                       overflow_q;
	logic                       all_star_q;
	logic [AW-1:0]              idx_q;
	logic                       prev_left_q;
	logic                       new_left_q;
	logic                       run_q;
	logic [wgm_pkg::CHAR_W-1:0] char_q;
	logic                       matched_q;
	logic                       ovf_out_q;

	logic [wgm_pkg::CHAR_W-1:0] rdata;
	logic [AW-1:0]              raddr;
	logic [AW-1:0]              last_idx;
	logic                       full;
	logic                       run_here;
	logic                       prev_here;
	logic                       v;
	logic                       end_match;

	assign full     = mask_length_q == LW'(MAX_MASK);
	assign last_idx = AW'(mask_length_q - LW'(1));
	// fetch the next mask position in the cycle before its use
	assign raddr    = cmd.step ? AW'(idx_q + AW'(1)) : '0;

	wgm_ram #(
		.WIDTH(wgm_pkg::CHAR_W),
		.DEPTH(MAX_MASK)
	) u_mask_ram (
		.clk  (clk),
		.we   (cmd.append && !full),
		.waddr(mask_length_q[AW-1:0]),
		.wdata(character),
		.raddr(raddr),
		.rdata(rdata)
	);

	// At string start the old column is the run of leading stars.
	always_comb begin
		run_here  = run_q && (rdata == wgm_pkg::STAR_CODE);
		prev_here = at_start_q ? run_here : bits_q[idx_q];
		if (rdata == wgm_pkg::STAR_CODE) begin
			v = new_left_q || prev_here;
		end else if (rdata == wgm_pkg::QMARK_CODE) begin
			v = prev_left_q;
		end else begin
			v = prev_left_q && (rdata == char_q);
		end
		if (at_start_q) begin
			end_match = all_star_q;
		end else begin
			end_match = (mask_length_q != '0) && bits_q[last_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_length_q <= '0;
			bits_q        <= '0;
			at_start_q    <= 1'b1;
			overflow_q    <= 1'b0;
			all_star_q    <= 1'b1;
			idx_q         <= '0;
		end else begin
			if (cmd.append) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					mask_length_q <= mask_length_q + LW'(1);
					all_star_q    <= all_star_q && (character == wgm_pkg::STAR_CODE);
				end
				bits_q     <= '0;
				at_start_q <= 1'b1;
			end
			if (cmd.clear) begin
				mask_length_q <= '0;
				overflow_q    <= 1'b0;
				all_star_q    <= 1'b1;
				bits_q        <= '0;
				at_start_q    <= 1'b1;
			end
			if (cmd.start) begin
				idx_q <= '0;
				if (mask_length_q == '0) begin
					at_start_q <= 1'b0;
				end
			end
			if (cmd.step) begin
				bits_q[idx_q] <= v;
				idx_q         <= idx_q + AW'(1);
				if (sts.walk_last) begin
					at_start_q <= 1'b0;
				end
			end
			if (cmd.finish) begin
				bits_q     <= '0;
				at_start_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			char_q      <= character;
			prev_left_q <= at_start_q;
			new_left_q  <= 1'b0;
			run_q       <= 1'b1;
		end
		if (cmd.step) begin
			new_left_q  <= v;
			prev_left_q <= prev_here;
			run_q       <= run_here;
		end
		if (cmd.finish) begin
			matched_q <= end_match;
			ovf_out_q <= overflow_q;
		end
	end

	assign sts.len_zero  = mask_length_q == '0;
	assign sts.walk_last = idx_q == last_idx;
	assign matched       = matched_q;
	assign mask_overflow = ovf_out_q;

endmodule
`default_nettype wire

>>> tb/wildcard_glob_matcher_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_glob_matcher: directed, overflow, back-pressure and
// random phases against an in-bench glob predictor. Depends on wgm_pkg, the wgm_if channel
// interfaces and the wildcard_glob_matcher RTL.
module wildcard_glob_matcher_test;

	localparam int MASK_DEPTH     = 64;
	localparam int RANDOM_ITEMS   = 350;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 2 * (MASK_DEPTH + 1);
	localparam int PRINT_CAP      = 30;

	localparam int                CHAR_W     = wgm_pkg::CHAR_W;
	localparam logic [CHAR_W-1:0] STAR_CODE  = wgm_pkg::STAR_CODE;
	localparam logic [CHAR_W-1:0] QMARK_CODE = wgm_pkg::QMARK_CODE;

	localparam logic [CHAR_W-1:0] TOP_CODE  = '1;
	localparam logic [CHAR_W-1:0] LAST_UNI  = CHAR_W'(1114111);
	localparam logic [CHAR_W-1:0] LETTER_A  = CHAR_W'(97);

	typedef logic [CHAR_W-1:0] code_q_t[$];

	typedef struct packed {
		logic matched;
		logic mask_overflow;
	} verdict_t;

	logic clk;
	logic arst_n;

	wgm_item_if   item_ch ();
	wgm_result_if result_ch ();

	wildcard_glob_matcher #(
		.MAX_MASK(MASK_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	// Predictor state
	logic [CHAR_W-1:0]     mask_ref [MASK_DEPTH];
	int                    mask_fill;
	logic [MASK_DEPTH-1:0] prefix_hits;
	bit                    fresh_string;
	bit                    dropped_any;

	verdict_t expected_verdicts[$];

	int  mismatches;
	int  items_sent;
	int  results_seen;
	int  matches_seen;
	int  overflow_seen;
	int  idle_cycles;
	int  stall_pct;
	int  gap_max;
	int  burst_left;
	bit  hold_off_request;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Column for the empty string: a prefix matches only while it is all stars.
	function automatic logic [MASK_DEPTH-1:0] star_run_column();
		logic [MASK_DEPTH-1:0] col;
		bit                    run;
		col = '0;
		run = 1'b1;
		for (int i = 0; i < mask_fill; i++) begin
			run    = run && (mask_ref[i] == STAR_CODE);
			col[i] = run;
		end
		return col;
	endfunction

	function automatic void predict_item(input wgm_pkg::op_t op, input logic [CHAR_W-1:0] ch);
		logic [MASK_DEPTH-1:0] next_hits;
		logic [CHAR_W-1:0]     m;
		bit                    left_prev;
		bit                    left_new;
		bit                    here;
		bit                    v;
		verdict_t              verdict;
		case (op)
			wgm_pkg::OP_APPEND: begin
				if (mask_fill < MASK_DEPTH) begin
					mask_ref[mask_fill] = ch;
					mask_fill++;
				end else
					dropped_any = 1'b1;
				prefix_hits  = '0;
				fresh_string = 1'b1;
			end
			wgm_pkg::OP_CLEAR: begin
				mask_fill    = 0;
				dropped_any  = 1'b0;
				prefix_hits  = '0;
				fresh_string = 1'b1;
			end
			wgm_pkg::OP_CHAR: begin
				if (fresh_string)
					prefix_hits = star_run_column();
				left_prev = fresh_string;
				left_new  = 1'b0;
				next_hits = '0;
				for (int i = 0; i < mask_fill; i++) begin
					m    = mask_ref[i];
					here = prefix_hits[i];
					if (m == STAR_CODE)
						v = left_new || here;
					else if (m == QMARK_CODE)
						v = left_prev;
					else
						v = left_prev && (m == ch);
					next_hits[i] = v;
					left_new     = v;
					left_prev    = here;
				end
				prefix_hits  = next_hits;
				fresh_string = 1'b0;
			end
			default: begin
				if (fresh_string)
					prefix_hits = star_run_column();
				verdict.matched       = (mask_fill == 0) ? fresh_string
				                                         : prefix_hits[mask_fill-1];
				verdict.mask_overflow = dropped_any;
				expected_verdicts.push_back(verdict);
				prefix_hits  = '0;
				fresh_string = 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic got, input logic want);
		if (mismatches < PRINT_CAP)
			$display("%t mismatch on result %0d: %s got %b expected %b",
			         $realtime, results_seen, what, got, want);
		mismatches++;
	endtask

	// Offer one item, hold it until the transfer, then maybe open a gap.
	task automatic send_item(input wgm_pkg::op_t op, input logic [CHAR_W-1:0] ch);
		int gap;
		item_ch.valid     <= 1'b1;
		item_ch.operation <= op;
		item_ch.character <= ch;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predict_item(op, ch);
		items_sent++;
		if (burst_left > 0)
			burst_left--;
		else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
			                                         : $urandom_range(0, 10);
			if (gap_max > 0) begin
				gap = $urandom_range(1, gap_max);
				item_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [CHAR_W-1:0] text_char();
		case ($urandom_range(0, 9))
			0:       return CHAR_W'($urandom_range(0, 2097151));
			1:       return $urandom_range(0, 1) ? STAR_CODE : QMARK_CODE;
			default: return LETTER_A + CHAR_W'($urandom_range(0, 2));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] mask_char();
		case ($urandom_range(0, 9))
			0, 1:    return STAR_CODE;
			2:       return QMARK_CODE;
			3:       return CHAR_W'($urandom_range(0, 2097151));
			default: return LETTER_A + CHAR_W'($urandom_range(0, 2));
		endcase
	endfunction

	// Build a string that fits the stored part of the mask, optionally spoiled.
	function automatic code_q_t subject_for(input code_q_t m, input bit spoil);
		code_q_t s;
		int      n;
		for (int i = 0; i < m.size() && i < MASK_DEPTH; i++) begin
			if (m[i] == STAR_CODE) begin
				n = $urandom_range(0, 3);
				repeat (n) s.push_back(text_char());
			end else if (m[i] == QMARK_CODE)
				s.push_back(text_char());
			else
				s.push_back(m[i]);
		end
		if (spoil) begin
			case ($urandom_range(0, 2))
				0: if (s.size() > 0) s[$urandom_range(0, s.size() - 1)] = text_char();
				1: s.push_back(text_char());
				default: if (s.size() > 0) s.delete($urandom_range(0, s.size() - 1));
			endcase
		end
		return s;
	endfunction

	task automatic load_mask(input code_q_t m);
		send_item(wgm_pkg::OP_CLEAR, CHAR_W'($urandom_range(0, 2097151)));
		foreach (m[i]) send_item(wgm_pkg::OP_APPEND, m[i]);
	endtask

	task automatic send_string(input code_q_t s);
		foreach (s[i]) send_item(wgm_pkg::OP_CHAR, s[i]);
		send_item(wgm_pkg::OP_END, CHAR_W'($urandom_range(0, 2097151)));
	endtask

	task automatic test_directed();
		stall_pct = 30;
		gap_max   = 3;
		send_item(wgm_pkg::OP_END, '0);                   // empty mask, empty string
		send_item(wgm_pkg::OP_CHAR, '0);
		send_item(wgm_pkg::OP_END, TOP_CODE);             // empty mask, one char
		send_item(wgm_pkg::OP_APPEND, STAR_CODE);
		send_item(wgm_pkg::OP_END, '0);                   // star-only mask, empty string
		send_item(wgm_pkg::OP_CHAR, TOP_CODE);
		send_item(wgm_pkg::OP_CHAR, '0);
		send_item(wgm_pkg::OP_END, '0);
		send_item(wgm_pkg::OP_APPEND, QMARK_CODE);
		send_item(wgm_pkg::OP_END, '0);                   // "*?" needs one char
		send_item(wgm_pkg::OP_CHAR, LAST_UNI);
		send_item(wgm_pkg::OP_END, '0);
		send_item(wgm_pkg::OP_CLEAR, TOP_CODE);
		send_item(wgm_pkg::OP_APPEND, LETTER_A);
		send_item(wgm_pkg::OP_APPEND, TOP_CODE);          // raw code above the Unicode range
		send_item(wgm_pkg::OP_CHAR, LETTER_A);
		send_item(wgm_pkg::OP_APPEND, QMARK_CODE);        // mask char abandons the string
		send_item(wgm_pkg::OP_CHAR, LETTER_A);
		send_item(wgm_pkg::OP_CHAR, TOP_CODE);
		send_item(wgm_pkg::OP_CHAR, CHAR_W'(5));
		send_item(wgm_pkg::OP_END, '0);
		send_item(wgm_pkg::OP_CHAR, LETTER_A);
		send_item(wgm_pkg::OP_END, '0);
		send_item(wgm_pkg::OP_CLEAR, '0);
		send_item(wgm_pkg::OP_END, '0);
	endtask

	task automatic test_mask_overflow();
		code_q_t m;
		stall_pct = 20;
		gap_max   = 2;
		repeat (MASK_DEPTH) m.push_back(mask_char());
		load_mask(m);
		send_string(subject_for(m, 1'b0));       // full store, no overflow yet
		send_string(subject_for(m, 1'b1));
		repeat (3) send_item(wgm_pkg::OP_APPEND, mask_char());
		send_item(wgm_pkg::OP_END, '0);          // overflow flagged
		send_string(subject_for(m, 1'b0));       // dropped chars leave the mask as it was
		send_item(wgm_pkg::OP_CLEAR, '0);
		send_item(wgm_pkg::OP_END, '0);          // clear drops the flag
	endtask

	task automatic test_backpressure();
		code_q_t m;
		stall_pct = 0;
		gap_max   = 0;
		m.push_back(STAR_CODE);
		m.push_back(LETTER_A);
		load_mask(m);
		hold_off_request = 1'b1;
		repeat (16) begin
			send_item(wgm_pkg::OP_CHAR, LETTER_A);
			send_item(wgm_pkg::OP_END, '0);
		end
		send_string(subject_for(m, 1'b1));
	endtask

	task automatic test_random();
		code_q_t m;
		int      start_count;
		int      mask_len;
		int      strings;
		start_count = items_sent;
		while (items_sent < start_count + RANDOM_ITEMS) begin
			if ($urandom_range(0, 5) == 0) begin
				case ($urandom_range(0, 3))
					0:       stall_pct = 0;
					1:       stall_pct = 25;
					2:       stall_pct = 50;
					default: stall_pct = 85;
				endcase
				gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 12);
			end
			if ($urandom_range(0, 9) == 0) begin
				// noise, including strings cut short by mask edits
				repeat ($urandom_range(1, 6))
					send_item(wgm_pkg::op_t'($urandom_range(0, 3)),
					          ($urandom_range(0, 1) != 0) ? CHAR_W'($urandom_range(0, 2097151))
					                                      : mask_char());
			end else begin
				if (m.size() == 0 || $urandom_range(0, 2) == 0) begin
					m.delete();
					mask_len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, MASK_DEPTH + 3)
					                                        : $urandom_range(0, 8);
					repeat (mask_len) m.push_back(mask_char());
					load_mask(m);
				end
				strings = $urandom_range(1, 4);
				repeat (strings) send_string(subject_for(m, $urandom_range(0, 3) == 0));
			end
		end
	endtask

	// Result receiver: random stalls, or one long hold-off on request.
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_request) begin
				result_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_request = 1'b0;
			end else
				result_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				if (mismatches < PRINT_CAP)
					$display("%t result with no item behind it", $realtime);
				mismatches++;
			end else begin
				want = expected_verdicts.pop_front();
				if (result_ch.matched !== want.matched)
					report_mismatch("matched", result_ch.matched, want.matched);
				if (result_ch.mask_overflow !== want.mask_overflow)
					report_mismatch("mask_overflow", result_ch.mask_overflow, want.mask_overflow);
			end
			results_seen++;
			matches_seen  += (result_ch.matched === 1'b1);
			overflow_seen += (result_ch.mask_overflow === 1'b1);
		end
	end

	// Watchdog: end the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("%t no transfer for %0d cycles", $realtime, WATCHDOG_LIMIT);
				$display("wildcard_glob_matcher regression: fail");
				$finish;
			end
		end
	end

	initial begin
		int waited;
		mask_fill         = 0;
		prefix_hits       = '0;
		fresh_string      = 1'b1;
		dropped_any       = 1'b0;
		mismatches        = 0;
		items_sent        = 0;
		results_seen      = 0;
		matches_seen      = 0;
		overflow_seen     = 0;
		idle_cycles       = 0;
		stall_pct         = 30;
		gap_max           = 3;
		burst_left        = 0;
		hold_off_request  = 1'b0;
		waited            = 0;
		arst_n            = 1'b0;
		item_ch.valid     <= 1'b0;
		item_ch.operation <= wgm_pkg::OP_CLEAR;
		item_ch.character <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_mask_overflow();
		test_backpressure();
		test_random();

		item_ch.valid <= 1'b0;
		stall_pct = 20;
		while (expected_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_verdicts.size() != 0) begin
			$display("%0d results never arrived", expected_verdicts.size());
			$display("wildcard_glob_matcher regression: fail");
			$finish;
		end else begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			$display("covered %0d items and %0d end-of-string results", items_sent, results_seen);
			$display("%0d results matched, %0d carried the overflow flag, %0d mismatches",
			         matches_seen, overflow_seen, mismatches);
			if (mismatches == 0)
				$display("wildcard_glob_matcher regression: pass");
			else
				$display("wildcard_glob_matcher regression: fail");
			$finish;
		end
	end

endmodule
